@@ rtl/wpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types, codes and helpers of the waveform point decimator.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PT_AW      = 10;     // point store address width
  localparam int PC_W       = 11;     // point count width (holds MAX_POINTS)
  localparam int DVD_W      = 42;     // divider dividend width
  localparam int DVS_W      = 25;     // divider divisor width
  localparam int QUO_W      = 16;     // divider quotient width

  localparam logic [15:0] RESET_CENTRE = 16'd2048;
  localparam logic [21:0] DECAY_RECIP  = 22'd3355444;  // ceil(2^24 / 5)

  localparam logic [2:0] CMD_FRAME_START = 3'd0;
  localparam logic [2:0] CMD_SAMPLE      = 3'd1;
  localparam logic [2:0] CMD_FRAME_END   = 3'd2;
  localparam logic [2:0] CMD_DECAY       = 3'd3;
  localparam logic [2:0] CMD_READ        = 3'd4;

  localparam logic [2:0] CFG_FORMAT   = 3'd0;
  localparam logic [2:0] CFG_CHANNELS = 3'd1;
  localparam logic [2:0] CFG_FRAME    = 3'd2;
  localparam logic [2:0] CFG_POINTS   = 3'd3;
  localparam logic [2:0] CFG_HEIGHT   = 3'd4;

  localparam logic [2:0] FMT_S8    = 3'd0;
  localparam logic [2:0] FMT_U8    = 3'd1;
  localparam logic [2:0] FMT_S16   = 3'd2;
  localparam logic [2:0] FMT_U16   = 3'd3;
  localparam logic [2:0] FMT_S32   = 3'd4;
  localparam logic [2:0] FMT_FLOAT = 3'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] left_word;
    logic [31:0] right_word;
    logic [9:0]  point_index;
  } wpd_in_t;

  typedef struct packed {
    logic [15:0] y_value;
    logic        any_moved;
  } wpd_out_t;

  typedef struct packed {
    logic                    use_div;
    logic                    neg;
    logic [DVD_W-1:0]        dividend;
    logic [DVS_W-1:0]        divisor;
    logic signed [15:0]      direct_q;
  } wpd_norm_t;

  // Apply sign to a rounded magnitude and saturate positive full scale.
  function automatic logic signed [15:0] apply_sign(input logic neg, input logic [15:0] mag);
    logic signed [15:0] res;
    if (neg) begin
      res = -$signed(mag);
    end else if (mag > 16'd32767) begin
      res = 16'sd32767;
    end else begin
      res = $signed(mag);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/wpd_point_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_point_ram
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wpd_point_ram
  import wpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PT_AW-1:0] waddr,
  input  wire logic [15:0]      wdata,
  input  wire logic [PT_AW-1:0] raddr,
  output logic      [15:0]      rdata
);

  logic [15:0] mem_r [MAX_POINTS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/wpd_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_divider
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpd_divider
  import wpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [QUO_W-1:0] quotient
);

  localparam int SH_W  = DVS_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [DVD_W-1:0] rem_r;
  logic [SH_W-1:0]  dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             fits;

  assign fits = rem_r >= DVD_W'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        dsh_r  <= {divisor, {(QUO_W-1){1'b0}}};
        quo_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // subtract the shifted divisor where it fits
        if (fits) begin
          rem_r <= rem_r - DVD_W'(dsh_r);
        end
        quo_r <= {quo_r[QUO_W-2:0], fits};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ rtl/wpd_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_norm
// Sample normalization front end: direct Q1.15 result or a divide request.
// ----------------------------------------------------------------------------
module wpd_norm
  import wpd_pkg::*;
(
  input  wire logic [2:0]  fmt,
  input  wire logic [1:0]  chan,
  input  wire logic [31:0] lw,
  input  wire logic [31:0] rw,
  output wpd_norm_t        norm
);

  // float32 to a signed 2^-24 step, clamped; NaN and subnormals read as 0
  function automatic logic signed [25:0] f24(input logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] m;
    logic [24:0] mag;
    logic [7:0]  sh;
    e   = w[30:23];
    m   = w[22:0];
    sh  = 8'd126 - e;
    if (e == 8'hFF) begin
      mag = (m != 23'd0) ? 25'd0 : 25'h1000000;
    end else if (e == 8'd0) begin
      mag = 25'd0;
    end else if (e >= 8'd127) begin
      mag = 25'h1000000;
    end else if (sh > 8'd24) begin
      mag = 25'd0;
    end else begin
      mag = {1'b0, ({1'b1, m} >> sh[4:0])};
    end
    return w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic [31:0] offs(input logic [2:0] f, input logic [31:0] w);
    logic [31:0] u;
    case (f)
      FMT_S8:  u = {24'd0, w[7:0] ^ 8'h80};
      FMT_U8:  u = {24'd0, w[7:0]};
      FMT_S16: u = {16'd0, w[15:0] ^ 16'h8000};
      FMT_U16: u = {16'd0, w[15:0]};
      default: u = w ^ 32'h80000000;
    endcase
    return u;
  endfunction

  logic               two;
  logic signed [26:0] fsum;
  logic [25:0]        fmag;
  logic [26:0]        frnd;
  logic [32:0]        su;
  logic signed [35:0] nf;
  logic signed [35:0] d;
  logic [34:0]        dmag;
  logic [35:0]        irnd;
  logic [15:0]        dir_mag;
  logic               dir_neg;

  always_comb begin
    two  = chan >= 2'd2;
    fsum = 27'(f24(lw)) + (two ? 27'(f24(rw)) : 27'sd0);
    fmag = fsum[26] ? 26'(-fsum) : fsum[25:0];
    frnd = 27'(fmag) + (two ? 27'd512 : 27'd256);

    su = 33'(offs(fmt, lw)) + (two ? 33'(offs(fmt, rw)) : 33'd0);
    if (fmt <= FMT_U8) begin
      nf = two ? 36'sd510 : 36'sd255;
    end else if (fmt <= FMT_U16) begin
      nf = two ? 36'sd131070 : 36'sd65535;
    end else begin
      nf = two ? 36'sh200000000 : 36'sh100000000;
    end
    d    = $signed({2'b00, su, 1'b0}) - nf;
    dmag = d[35] ? 35'(-d) : d[34:0];
    irnd = 36'(dmag) + (two ? 36'h20000 : 36'h10000);

    if (fmt >= FMT_FLOAT) begin
      dir_neg = fsum[26];
      dir_mag = two ? frnd[25:10] : frnd[24:9];
    end else begin
      dir_neg = d[35];
      dir_mag = two ? irnd[33:18] : irnd[32:17];
    end

    norm.use_div  = fmt < FMT_S32;
    norm.neg      = d[35];
    norm.dividend = DVD_W'({dmag[17:0], 15'd0}) + DVD_W'(nf[17:1]);
    norm.divisor  = DVS_W'(nf[16:0]);
    norm.direct_q = apply_sign(dir_neg, dir_mag);
  end

endmodule
`default_nettype wire

@@ rtl/waveform_point_decimator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_point_decimator_unit
// Audio frames to waveform display points, with decay and point readout.
// ----------------------------------------------------------------------------
// Takes one command word at a time; in_stall is high while a command is at
// work and during the clearing pass. After reset a clearing pass writes the
// centre line (2048) into all 1024 point entries; configuration writes are
// taken during it and at any time (cfg_ready is always high). A sample uses
// two serial divides (normalization of 8- and 16-bit formats, then the group
// mean into y) that share one divider unit; s32 and float32 skip the first
// divide. Frame end writes one point per cycle. A decay step sweeps the point
// store read, modify, write over the points in use. Results sit in an output
// register, so the next command is accepted while a result still waits on
// out_stall.
// ----------------------------------------------------------------------------
module waveform_point_decimator_unit
  import wpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire wpd_in_t  in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output wpd_out_t      out_word,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_NORM, S_NDIV, S_ACC, S_YMUL, S_YSTART, S_YDIV,
    S_FILLG, S_FEND, S_DRD, S_DT, S_DWR, S_RRD, S_RWT, S_RES
  } state_t;

  state_t             state_r;
  wpd_in_t            in_word_r;
  logic [2:0]         fmt_r;
  logic [1:0]         chan_r;
  logic [12:0]        fsc_r;
  logic [10:0]        ptc_r;
  logic [11:0]        hgt_r;
  logic signed [31:0] gsum_r;
  logic [12:0]        gcnt_r;
  logic [12:0]        taken_r;
  logic [13:0]        spread_r;
  logic [PC_W-1:0]    nextp_r;
  logic [15:0]        lasty_r;
  logic signed [15:0] q_r;
  logic [40:0]        prod_r;
  logic [PC_W-1:0]    idx_r;
  logic               found_r;
  logic               dneg_r;
  logic               dnz_r;
  logic [17:0]        t_r;
  wpd_out_t           res_r;
  logic               out_valid_r;
  wpd_out_t           out_word_r;

  logic [PC_W-1:0]    pc;
  logic [15:0]        centre;
  logic               accept;
  wpd_norm_t          norm;
  logic               ram_we;
  logic [PT_AW-1:0]   ram_waddr;
  logic [15:0]        ram_wdata;
  logic [PT_AW-1:0]   ram_raddr;
  logic [15:0]        ram_rdata;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic signed [32:0] ydiff;
  logic [13:0]        spread_less;
  logic signed [16:0] dy;
  logic [15:0]        dmag;
  logic [19:0]        dmul;
  logic [39:0]        dprod;
  logic [15:0]        dq;
  logic [15:0]        dnew;

  assign pc        = (ptc_r > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : ptc_r;
  assign centre    = {1'b0, hgt_r, 3'b000};
  assign in_stall  = state_r != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  wpd_norm u_norm (
    .fmt  (fmt_r),
    .chan (chan_r),
    .lw   (in_word_r.left_word),
    .rw   (in_word_r.right_word),
    .norm (norm)
  );

  wpd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  wpd_point_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // y numerator term and decay arithmetic
  always_comb begin
    ydiff       = $signed({1'b0, gcnt_r, 15'd0}) - 33'(gsum_r);
    spread_less = spread_r - 14'(fsc_r);
    dy          = $signed({1'b0, ram_rdata}) - $signed({1'b0, centre});
    dmag        = dy[16] ? 16'(-dy) : dy[15:0];
    dmul        = {dmag, 3'b000} + {2'b00, dmag, 2'b00} + 20'(dmag) + 20'd10;
    dprod       = 40'(t_r) * 40'(DECAY_RECIP);
    dq          = dprod[39:24];
    if (dq < 16'd16) begin
      dnew = centre;
    end else if (dneg_r) begin
      dnew = centre - dq;
    end else begin
      dnew = centre + dq;
    end
  end

  // divider start, point store ports
  always_comb begin
    div_start    = 1'b0;
    div_dividend = norm.dividend;
    div_divisor  = norm.divisor;
    ram_we       = 1'b0;
    ram_waddr    = nextp_r[PT_AW-1:0];
    ram_wdata    = lasty_r;
    ram_raddr    = idx_r[PT_AW-1:0];
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[PT_AW-1:0];
        ram_wdata = RESET_CENTRE;
      end
      S_NORM: begin
        div_start = norm.use_div;
      end
      S_YSTART: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(prod_r) + DVD_W'({gcnt_r, 11'd0});
        div_divisor  = DVS_W'({gcnt_r, 12'd0});
      end
      S_FILLG: begin
        ram_we = 1'b1;
      end
      S_FEND: begin
        ram_we = nextp_r < pc;
      end
      S_DWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[PT_AW-1:0];
        ram_wdata = dnew;
      end
      S_RRD: begin
        ram_raddr = in_word_r.point_index;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      fmt_r       <= FMT_FLOAT;
      chan_r      <= 2'd1;
      fsc_r       <= 13'd1200;
      ptc_r       <= 11'd4;
      hgt_r       <= 12'd256;
      gsum_r      <= '0;
      gcnt_r      <= '0;
      taken_r     <= '0;
      spread_r    <= '0;
      nextp_r     <= '0;
      lasty_r     <= RESET_CENTRE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FORMAT:   fmt_r  <= cfg_data[2:0];
          CFG_CHANNELS: chan_r <= cfg_data[1:0];
          CFG_FRAME:    fsc_r  <= cfg_data[12:0];
          CFG_POINTS:   ptc_r  <= cfg_data[10:0];
          CFG_HEIGHT:   hgt_r  <= cfg_data[11:0];
          default: begin
          end
        endcase
      end

      // drop the result once taken, unless a new one loads in its place
      if (out_valid_r && !out_stall && state_r != S_RES) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == PC_W'(MAX_POINTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            in_word_r <= in_word;
            case (in_word.command)
              CMD_FRAME_START: begin
                gsum_r   <= '0;
                gcnt_r   <= '0;
                taken_r  <= '0;
                spread_r <= '0;
                nextp_r  <= '0;
                lasty_r  <= centre;
              end
              CMD_SAMPLE: begin
                if (nextp_r < pc && taken_r < fsc_r) begin
                  state_r <= S_NORM;
                end
              end
              CMD_FRAME_END: begin
                state_r <= S_FEND;
              end
              CMD_DECAY: begin
                idx_r   <= '0;
                found_r <= 1'b0;
                state_r <= S_DRD;
              end
              CMD_READ: begin
                state_r <= S_RRD;
              end
              default: begin
              end
            endcase
          end
        end
        S_NORM: begin
          if (norm.use_div) begin
            state_r <= S_NDIV;
          end else begin
            q_r     <= norm.direct_q;
            state_r <= S_ACC;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            q_r     <= apply_sign(norm.neg, div_quo);
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          gsum_r   <= gsum_r + 32'(q_r);
          gcnt_r   <= gcnt_r + 1'b1;
          taken_r  <= taken_r + 1'b1;
          spread_r <= spread_r + 14'(pc);
          state_r  <= S_YMUL;
        end
        S_YMUL: begin
          prod_r  <= 41'(hgt_r) * 41'(ydiff[28:0]);
          state_r <= S_YSTART;
        end
        S_YSTART: begin
          state_r <= S_YDIV;
        end
        S_YDIV: begin
          if (div_done) begin
            lasty_r <= div_quo;
            state_r <= (spread_r >= 14'(fsc_r)) ? S_FILLG : S_IDLE;
          end
        end
        S_FILLG: begin
          // write one point per cycle while spread >= frame and points remain
          nextp_r  <= nextp_r + 1'b1;
          spread_r <= spread_less;
          if (!(spread_less >= 14'(fsc_r) && (nextp_r + 1'b1) < pc)) begin
            gsum_r  <= '0;
            gcnt_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        S_FEND: begin
          if (nextp_r < pc) begin
            nextp_r <= nextp_r + 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DRD: begin
          if (idx_r < pc) begin
            state_r <= S_DT;
          end else begin
            res_r   <= '{y_value: 16'd0, any_moved: found_r};
            state_r <= S_RES;
          end
        end
        S_DT: begin
          dneg_r  <= dy[16];
          dnz_r   <= dy != 17'sd0;
          t_r     <= dmul[19:2];
          state_r <= S_DWR;
        end
        S_DWR: begin
          found_r <= found_r | dnz_r;
          idx_r   <= idx_r + 1'b1;
          state_r <= S_DRD;
        end
        S_RRD: begin
          state_r <= S_RWT;
        end
        S_RWT: begin
          res_r   <= '{y_value: ram_rdata, any_moved: 1'b0};
          state_r <= S_RES;
        end
        S_RES: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_word_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == S_FILLG || state_r == S_FEND)) |-> (nextp_r < pc))
    else $error("point write past points in use");

  a_group_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILLG && !(spread_less >= 14'(fsc_r) && (nextp_r + 1'b1) < pc))
    |=> (gcnt_r == 13'd0 && state_r == S_IDLE))
    else $error("group not closed after point writes");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && out_valid_r && out_stall) |=> (state_r == S_RES))
    else $error("result overwrote a waiting word");

endmodule
`default_nettype wire
